@@ hdl/sip_pkg.sv @@
package sip_pkg;

  localparam int unsigned FieldWidth = 8;
  localparam int unsigned PairWidth  = 2 * FieldWidth;

  localparam logic KindInsert = 1'b0;
  localparam logic KindRemove = 1'b1;

  localparam logic ModePriorityAsc = 1'b0;
  localparam logic ModeValueDesc   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_PLACE,
    ST_REM_RD,
    ST_POP,
    ST_FAIL
  } sip_state_e;

  typedef struct packed {
    logic load;
    logic rd_prev;
    logic rd_head;
    logic shift;
    logic place;
    logic pop;
    logic fail;
  } sip_cmd_t;

  typedef struct packed {
    logic kind_remove;
    logic full;
    logic empty;
    logic pos_one;
    logic shift_hit;
    logic out_free;
  } sip_sts_t;

endpackage

@@ hdl/sip_in_if.sv @@
interface sip_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    kind;
  logic signed [sip_pkg::FieldWidth-1:0]   item_value;
  logic signed [sip_pkg::FieldWidth-1:0]   item_priority;

  modport source (output valid, output kind, output item_value, output item_priority,
                  input ready);
  modport sink (input valid, input kind, input item_value, input item_priority,
                output ready);
endinterface

@@ hdl/sip_out_if.sv @@
interface sip_out_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    ok;
  logic signed [sip_pkg::FieldWidth-1:0]   out_value;
  logic signed [sip_pkg::FieldWidth-1:0]   out_priority;

  modport source (output valid, output ok, output out_value, output out_priority,
                  input ready);
  modport sink (input valid, input ok, input out_value, input out_priority,
                output ready);
endinterface

@@ hdl/sip_ram.sv @@
module sip_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sip_ctrl.sv @@
module sip_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sip_pkg::sip_sts_t sts_i,
  output sip_pkg::sip_cmd_t cmd_o
);

  sip_pkg::sip_state_e state_q, state_d;
  logic                accept;

  assign in_ready_o = (state_q == sip_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sip_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sip_pkg::ST_IDLE: begin
        if (accept) begin
          if (sts_i.kind_remove) begin
            state_d = sts_i.empty ? sip_pkg::ST_FAIL : sip_pkg::ST_REM_RD;
          end else if (sts_i.full) begin
            state_d = sip_pkg::ST_FAIL;
          end else if (sts_i.empty) begin
            state_d = sip_pkg::ST_PLACE;
          end else begin
            state_d = sip_pkg::ST_INS_RD;
          end
        end
      end
      sip_pkg::ST_INS_RD: begin
        state_d = sip_pkg::ST_INS_CMP;
      end
      sip_pkg::ST_INS_CMP: begin
        if (sts_i.shift_hit && !sts_i.pos_one) begin
          state_d = sip_pkg::ST_INS_RD;
        end else begin
          state_d = sip_pkg::ST_PLACE;
        end
      end
      sip_pkg::ST_PLACE: begin
        if (sts_i.out_free) begin
          state_d = sip_pkg::ST_IDLE;
        end
      end
      sip_pkg::ST_REM_RD: begin
        state_d = sip_pkg::ST_POP;
      end
      sip_pkg::ST_POP: begin
        if (sts_i.out_free) begin
          state_d = sip_pkg::ST_IDLE;
        end
      end
      sip_pkg::ST_FAIL: begin
        if (sts_i.out_free) begin
          state_d = sip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sip_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      sip_pkg::ST_IDLE:    cmd_o.load    = accept;
      sip_pkg::ST_INS_RD:  cmd_o.rd_prev = 1'b1;
      sip_pkg::ST_INS_CMP: cmd_o.shift   = sts_i.shift_hit;
      sip_pkg::ST_PLACE:   cmd_o.place   = sts_i.out_free;
      sip_pkg::ST_REM_RD:  cmd_o.rd_head = 1'b1;
      sip_pkg::ST_POP:     cmd_o.pop     = sts_i.out_free;
      sip_pkg::ST_FAIL:    cmd_o.fail    = sts_i.out_free;
      default:             cmd_o         = '0;
    endcase
  end

endmodule

@@ hdl/sip_datapath.sv @@
module sip_datapath #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_data_i,
  input  logic                                  kind_i,
  input  logic signed [sip_pkg::FieldWidth-1:0] item_value_i,
  input  logic signed [sip_pkg::FieldWidth-1:0] item_priority_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic                                  ok_o,
  output logic signed [sip_pkg::FieldWidth-1:0] out_value_o,
  output logic signed [sip_pkg::FieldWidth-1:0] out_priority_o,
  input  sip_pkg::sip_cmd_t                     cmd_i,
  output sip_pkg::sip_sts_t                     sts_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned FW = sip_pkg::FieldWidth;
  localparam int unsigned PW = sip_pkg::PairWidth;

  logic                 mode_q;
  logic [IW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic signed [FW-1:0] val_q, pri_q;
  logic                 out_valid_q, out_ok_q;
  logic signed [FW-1:0] out_val_q, out_pri_q;
  logic [PW-1:0]        rdata;
  logic                 ram_we, ram_re;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  logic [PW-1:0]        ram_wdata;
  logic                 result;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign ram_re    = cmd_i.rd_prev || cmd_i.rd_head;
  assign ram_raddr = cmd_i.rd_head ? head_q : slot_of(head_q, pos_q - CW'(1));
  assign ram_we    = cmd_i.shift || cmd_i.place;
  assign ram_waddr = slot_of(head_q, pos_q);
  assign ram_wdata = cmd_i.shift ? rdata : {val_q, pri_q};

  sip_ram #(
    .WIDTH (PW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    pos_d   = pos_q;
    if (cmd_i.load) begin
      pos_d = count_q;
    end
    if (cmd_i.shift) begin
      pos_d = pos_q - CW'(1);
    end
    if (cmd_i.place) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
      if (count_q == CW'(1) || head_q == IW'(QUEUE_DEPTH - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + IW'(1);
      end
    end
  end

  assign result = cmd_i.place || cmd_i.pop || cmd_i.fail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= sip_pkg::ModePriorityAsc;
      head_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      if (result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= item_value_i;
      pri_q <= item_priority_i;
    end
    if (result) begin
      out_ok_q  <= !cmd_i.fail;
      out_val_q <= cmd_i.pop ? $signed(rdata[PW-1:FW]) : '0;
      out_pri_q <= cmd_i.pop ? $signed(rdata[FW-1:0]) : '0;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.kind_remove = (kind_i == sip_pkg::KindRemove);
    sts_o.full        = (count_q == CW'(QUEUE_DEPTH));
    sts_o.empty       = (count_q == '0);
    sts_o.pos_one     = (pos_q == CW'(1));
    sts_o.out_free    = !out_valid_q || out_ready_i;
    if (mode_q == sip_pkg::ModeValueDesc) begin
      sts_o.shift_hit = $signed(rdata[PW-1:FW]) < val_q;
    end else begin
      sts_o.shift_hit = $signed(rdata[FW-1:0]) > pri_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = out_ok_q;
  assign out_value_o    = out_val_q;
  assign out_priority_o = out_pri_q;

endmodule

@@ hdl/sorted_insert_pair_queue.sv @@
// Bounded priority queue of signed (value, priority) pairs held in a circular RAM.
// Items arrive on in_i with valid/ready: kind selects an insert of the pair or a
// removal of the head pair. Every accepted item gives exactly one result on out_o:
// ok, and on a successful removal the pair taken from the head, else zeros.
// cfg_we_i writes the one-bit order mode (ascending priority or descending value);
// the user must write it only while the queue is idle, which the block does not
// enforce. One item is handled at a time. A removal reads the head slot, then pops
// it; a failed insert or removal goes straight to its result. An insert moves each
// entry that sorts behind the new pair back one slot and places the pair behind the
// first entry that stays in front, or at the head when every entry moves (at once
// into an empty queue). The insertion walk is set by the single RAM port pair: each
// slot is read in ST_INS_RD and compared and moved in ST_INS_CMP.
// The result is held in an output register; ready returns high once the result is
// in that register, and the next item waits before its own result until the
// register is free, so a stalled receiver holds the queue.
// After reset the queue is empty, the head is slot 0 and the mode is ascending
// priority. The RAM needs no clearing pass: only live entries are ever read.
module sorted_insert_pair_queue #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  sip_in_if.sink    in_i,
  sip_out_if.source out_o
);

  sip_pkg::sip_cmd_t cmd;
  sip_pkg::sip_sts_t sts;

  sip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sip_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .kind_i          (in_i.kind),
    .item_value_i    (in_i.item_value),
    .item_priority_i (in_i.item_priority),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .ok_o            (out_o.ok),
    .out_value_o     (out_o.out_value),
    .out_priority_o  (out_o.out_priority),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

`ifndef NO_ASSERTIONS
  a_place_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.place |-> !sts.full)
    else $error("Insert placed into a full queue.");

  a_pop_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.empty)
    else $error("Head removed from an empty queue.");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("Item accepted while the previous item is still in progress.");

  a_result_only_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.place || cmd.pop || cmd.fail) |-> sts.out_free)
    else $error("Result written over an undelivered result.");
`endif

endmodule

@@ verif/sorted_insert_pair_queue_tb.sv @@
`timescale 1ns / 100ps

module sorted_insert_pair_queue_tb;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned ItemTotal  = 1250;
  localparam int unsigned CalmTail   = 150;
  localparam int unsigned CycleLimit = 1000000;

  typedef struct packed {
    logic                                  ok;
    logic signed [sip_pkg::FieldWidth-1:0] value;
    logic signed [sip_pkg::FieldWidth-1:0] prio;
  } pair_result_t;

  typedef enum int unsigned {
    MixFill,
    MixEmpty,
    MixBalanced,
    MixNarrowKeys
  } phase_mix_e;

  class pair_queue_book;
    logic signed [sip_pkg::FieldWidth-1:0] slot_value [QueueDepth];
    logic signed [sip_pkg::FieldWidth-1:0] slot_prio  [QueueDepth];
    int unsigned  head_slot;
    int unsigned  fill;
    logic         order_mode;
    pair_result_t expected_results [$];
    int unsigned  accepted, inserts, removes, full_refusals, empty_refusals;
    int unsigned  checked, mismatches;

    function new();
      head_slot  = 0;
      fill       = 0;
      order_mode = sip_pkg::ModePriorityAsc;
    endfunction

    function void note_item(logic kind, logic signed [sip_pkg::FieldWidth-1:0] v,
                            logic signed [sip_pkg::FieldWidth-1:0] p);
      pair_result_t r;
      int unsigned  pos;
      int unsigned  src;
      int unsigned  dst;
      logic         moves;
      r = '0;
      accepted++;
      if (kind == sip_pkg::KindInsert) begin
        if (fill == QueueDepth) begin
          full_refusals++;
        end else begin
          pos = fill;
          while (pos > 0) begin
            src   = (head_slot + pos - 1) % QueueDepth;
            moves = (order_mode == sip_pkg::ModePriorityAsc) ? (slot_prio[src] > p)
                                                             : (slot_value[src] < v);
            if (!moves) break;
            dst = (head_slot + pos) % QueueDepth;
            slot_value[dst] = slot_value[src];
            slot_prio[dst]  = slot_prio[src];
            pos--;
          end
          dst = (head_slot + pos) % QueueDepth;
          slot_value[dst] = v;
          slot_prio[dst]  = p;
          fill++;
          inserts++;
          r.ok = 1'b1;
        end
      end else if (fill == 0) begin
        empty_refusals++;
      end else begin
        r.ok    = 1'b1;
        r.value = slot_value[head_slot];
        r.prio  = slot_prio[head_slot];
        fill--;
        head_slot = (fill == 0) ? 0 : (head_slot + 1) % QueueDepth;
        removes++;
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic ok, logic signed [sip_pkg::FieldWidth-1:0] v,
                               logic signed [sip_pkg::FieldWidth-1:0] p);
      pair_result_t want;
      checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result ok %0d value %0d priority %0d", $time, ok, v, p);
        return;
      end
      want = expected_results.pop_front();
      if (ok !== want.ok) begin
        mismatches++;
        $display("%0t: ok expected %0d, got %0d", $time, want.ok, ok);
      end
      if (v !== want.value) begin
        mismatches++;
        $display("%0t: out_value expected %0d, got %0d", $time, want.value, v);
      end
      if (p !== want.prio) begin
        mismatches++;
        $display("%0t: out_priority expected %0d, got %0d", $time, want.prio, p);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;

  sip_in_if  in_bus ();
  sip_out_if out_bus ();

  pair_queue_book book = new();

  logic        tx_idle = 1'b0;
  logic        rx_idle = 1'b0;
  int unsigned rx_stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mode_writes = 0;

  sorted_insert_pair_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, book.expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        book.note_item(in_bus.kind, in_bus.item_value, in_bus.item_priority);
      end
      if (out_bus.valid && out_bus.ready) begin
        book.check_result(out_bus.ok, out_bus.out_value, out_bus.out_priority);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_bus.ready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 9) == 0) begin
      rx_stall_left = $urandom_range(0, 18);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic kind,
                           input logic signed [sip_pkg::FieldWidth-1:0] v,
                           input logic signed [sip_pkg::FieldWidth-1:0] p);
    int unsigned gap;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_bus.valid         <= 1'b1;
    in_bus.kind          <= kind;
    in_bus.item_value    <= v;
    in_bus.item_priority <= p;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic settle_results();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (book.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    book.order_mode = mode;
    mode_writes++;
  endtask

  initial begin : stimulus
    logic                                  tail;
    logic                                  kind;
    logic signed [sip_pkg::FieldWidth-1:0] v;
    logic signed [sip_pkg::FieldWidth-1:0] p;
    phase_mix_e                            mix;
    int unsigned                           span;
    int unsigned                           insert_pct;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_data_i           = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.kind          = sip_pkg::KindInsert;
    in_bus.item_value    = '0;
    in_bus.item_priority = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_mode(sip_pkg::ModePriorityAsc);
    send_item(sip_pkg::KindRemove, 8'sd0, 8'sd0);
    send_item(sip_pkg::KindRemove, -8'sd1, -8'sd1);
    send_item(sip_pkg::KindInsert, 8'sd5, 8'sd10);
    send_item(sip_pkg::KindInsert, 8'sh80, 8'sh7f);
    send_item(sip_pkg::KindInsert, 8'sh7f, 8'sh80);
    send_item(sip_pkg::KindInsert, 8'sd0, 8'sd0);
    send_item(sip_pkg::KindInsert, 8'sd1, 8'sd10);
    send_item(sip_pkg::KindInsert, 8'sd2, 8'sd10);
    repeat (7) begin
      send_item(sip_pkg::KindRemove, 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end
    settle_results();
    write_mode(sip_pkg::ModeValueDesc);
    send_item(sip_pkg::KindInsert, 8'sd3, 8'sd1);
    send_item(sip_pkg::KindInsert, 8'sh7f, 8'sd0);
    send_item(sip_pkg::KindInsert, 8'sh80, 8'sd0);
    send_item(sip_pkg::KindInsert, 8'sd3, 8'sd2);
    send_item(sip_pkg::KindInsert, 8'sd3, -8'sd5);
    repeat (6) send_item(sip_pkg::KindRemove, 8'sd0, 8'sd0);

    while (book.accepted < ItemTotal) begin
      settle_results();
      write_mode(1'($urandom_range(0, 1)));
      tail    = (book.accepted + CalmTail >= ItemTotal);
      tx_idle = !tail && ($urandom_range(0, 3) != 0);
      rx_idle = !tail && ($urandom_range(0, 3) != 0);
      mix     = phase_mix_e'($urandom_range(0, 3));
      span    = $urandom_range(40, 120);
      case (mix)
        MixFill:  insert_pct = 85;
        MixEmpty: insert_pct = 20;
        default:  insert_pct = 55;
      endcase
      repeat (span) begin
        kind = ($urandom_range(0, 99) < insert_pct) ? sip_pkg::KindInsert
                                                    : sip_pkg::KindRemove;
        if (mix == MixNarrowKeys) begin
          v = 8'($urandom_range(254, 258));
          p = 8'($urandom_range(254, 258));
        end else begin
          v = 8'($urandom_range(0, 255));
          p = 8'($urandom_range(0, 255));
        end
        send_item(kind, v, p);
      end
    end

    settle_results();
    repeat (2 * QueueDepth + 8) @(posedge clk_i);
    $display("Checked %0d results from %0d items: %0d inserts, %0d removals,",
             book.checked, book.accepted, book.inserts, book.removes);
    $display("%0d refused when full, %0d when empty; the order mode was rewritten %0d times.",
             book.full_refusals, book.empty_refusals, mode_writes);
    if (book.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
